// ===== rtl/dpb_pkg.sv =====
// ---------------------------------------------------------------------------
// Decoded picture buffer package
// Shared types, constants and operation codes for the picture buffer core.
// ---------------------------------------------------------------------------
package dpb_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;

   // Operation codes.
   localparam logic [2:0] OP_ADD       = 3'd0;
   localparam logic [2:0] OP_FLUSH     = 3'd1;
   localparam logic [2:0] OP_SLIDING   = 3'd2;
   localparam logic [2:0] OP_MARK_LONG = 3'd3;
   localparam logic [2:0] OP_UNMARK_ST = 3'd4;
   localparam logic [2:0] OP_UNMARK_LT = 3'd5;
   localparam logic [2:0] OP_UNMARK_ALL = 3'd6;
   localparam logic [2:0] OP_LIST      = 3'd7;

   // Result kinds.
   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_ENTRY = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   // Slot flag bits.
   localparam int unsigned FLAG_REF  = 0;
   localparam int unsigned FLAG_LONG = 1;
   localparam int unsigned FLAG_PEND = 2;

   localparam logic [4:0]  MAX_FRAMES_RESET = 5'd16;
   localparam logic [16:0] MAX_LONG_RESET   = 17'h1FFFF;

   localparam logic [0:0] CSR_MAX_FRAMES = 1'b0;
   localparam logic [0:0] CSR_MAX_LONG   = 1'b1;

   // Width of one stored slot: tag, order count, frame index, flags.
   localparam int unsigned SLOT_W = 83;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] frame_tag;
      logic [31:0] order_count;
      logic [15:0] frame_index;
      logic [15:0] new_long_index;
      logic        is_ref;
      logic        is_long;
      logic        needs_output;
      logic        flush_emit;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] out_tag;
      logic [31:0] out_order_count;
      logic [15:0] out_frame_index;
      logic        out_is_long;
      logic        out_is_ref;
      logic        entry_valid;
      logic        status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] poc;
      logic [15:0] idx;
      logic [2:0]  flags;
   } slot_type;

endpackage

// ===== rtl/dpb_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one registered read port, parameterized width and depth.
// ---------------------------------------------------------------------------
module dpb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/h264_decoded_picture_buffer_core.sv =====
// ---------------------------------------------------------------------------
// Decoded picture buffer core
// Frame store with output bumping, reference marking and slot compaction.
// ---------------------------------------------------------------------------
// The block takes one operation transaction on the req_ channel and answers
// with one or more result transactions on the rsp_ channel; the last result
// of an operation carries last. Configuration is to be written on the csr_
// port only while the block is idle; the block itself does not enforce this.
// Slots live in one RAM that is read one entry per cycle while no held
// result stalls the walk; a sequencer walks the slots for every scan, bump
// and compaction, and the RAM read port sets the pace of these walks.
// req_stall is high from acceptance until the last result is taken. A result
// is held in an output register; while a held result sees rsp_stall high,
// the sequencer waits before it produces another result.
// Reset empties the buffer (the stored count is cleared) and restores the
// register defaults; slot contents are not cleared and need not be.
// ---------------------------------------------------------------------------
module h264_decoded_picture_buffer_core #(
   parameter int unsigned DPB_DEPTH = dpb_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dpb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dpb_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [0:0]       csr_index,
   input  logic [16:0]      csr_wdata
);

   localparam int unsigned AW = $clog2(DPB_DEPTH);
   localparam int unsigned CW = $clog2(DPB_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DPB_DEPTH);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;  // issue reads over slots
   localparam logic [3:0] S_DECIDE = 4'd2;  // act on scan result
   localparam logic [3:0] S_RDSEL  = 4'd3;  // read chosen slot
   localparam logic [3:0] S_ACT    = 4'd4;  // modify chosen slot
   localparam logic [3:0] S_SHIFT  = 4'd5;  // compaction move
   localparam logic [3:0] S_SENDW  = 4'd6;  // wait for result to leave
   localparam logic [3:0] S_DONE   = 4'd7;
   localparam logic [3:0] S_LIST   = 4'd8;
   localparam logic [3:0] S_ADDNEW = 4'd9;
   localparam logic [3:0] S_RDWAIT = 4'd10;

   // Scan goals.
   localparam logic [1:0] G_PEND  = 2'd0;  // lowest pending order count
   localparam logic [1:0] G_SLIDE = 2'd1;  // lowest short-term frame index
   localparam logic [1:0] G_MATCH = 2'd2;  // first matching frame index
   localparam logic [1:0] G_ALL   = 2'd3;  // first reference, for unmark all

   logic [3:0]       state_ff, state_in;
   logic [3:0]       ret_ff, ret_in;
   dpb_pkg::req_type req_ff, req_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [4:0]       maxf_ff, maxf_in;
   logic [16:0]      maxl_ff, maxl_in;
   logic [1:0]       goal_ff, goal_in;
   logic [CW-1:0]    rd_ff, rd_in;       // next read address
   logic [CW-1:0]    cmp_ff, cmp_in;     // address of data now on rd_data
   logic             cmpv_ff, cmpv_in;
   logic             found_ff, found_in;
   logic [AW-1:0]    best_ff, best_in;
   logic [31:0]      bkey_ff, bkey_in;
   logic [CW-1:0]    pos_ff, pos_in;     // compaction cursor
   logic             status_ff, status_in;
   logic             ovalid_ff, ovalid_in;
   dpb_pkg::rsp_type odata_ff, odata_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   dpb_pkg::slot_type     wr_slot, rd_slot;
   logic [AW-1:0]         rd_addr;
   logic [dpb_pkg::SLOT_W-1:0] rd_bits;

   dpb_ram #(.WIDTH(dpb_pkg::SLOT_W), .DEPTH(DPB_DEPTH)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_slot = dpb_pkg::slot_type'(rd_bits);
   assign rd_addr = rd_ff[AW-1:0];

   logic [CW-1:0] cap;
   assign cap = (32'(maxf_ff) > DPB_DEPTH) ? DEPTH_C : CW'(maxf_ff);

   // Candidate test and key for the shared compare unit.
   logic        cand;
   logic [31:0] key;
   logic        better;
   always_comb begin
      cand = 1'b0;
      key  = rd_slot.poc;
      case (goal_ff)
         G_PEND: begin
            cand = rd_slot.flags[dpb_pkg::FLAG_PEND];
            key  = rd_slot.poc;
         end
         G_SLIDE: begin
            cand = rd_slot.flags[dpb_pkg::FLAG_REF] && !rd_slot.flags[dpb_pkg::FLAG_LONG];
            key  = {16'd0, rd_slot.idx};
         end
         G_MATCH: begin
            cand = rd_slot.flags[dpb_pkg::FLAG_REF]
                && (rd_slot.flags[dpb_pkg::FLAG_LONG]
                    == (req_ff.operation == dpb_pkg::OP_UNMARK_LT))
                && (rd_slot.idx == req_ff.frame_index);
            key  = 32'd0;
         end
         default: begin
            cand = rd_slot.flags[dpb_pkg::FLAG_REF];
            key  = 32'd0;
         end
      endcase
      better = cand && (!found_ff || key < bkey_ff);
   end

   // Pending-frame limit for bumping. Without a frame limit, a count at the
   // top of the range is never below the limit and cannot be bumped.
   logic        bump_ok;
   logic        nonref_add;
   always_comb begin
      nonref_add = (req_ff.operation == dpb_pkg::OP_ADD) && !req_ff.is_ref;
      bump_ok = found_ff && (nonref_add ? (bkey_ff < req_ff.order_count)
                                        : (bkey_ff != 32'hFFFFFFFF));
   end

   logic out_free;
   assign out_free = !ovalid_ff || !rsp_stall;

   logic        eff_ref;
   always_comb begin
      eff_ref = req_data.is_ref;
      if (req_data.is_ref && req_data.is_long
          && $signed({1'b0, req_data.frame_index}) > $signed(maxl_ff)) begin
         eff_ref = 1'b0;
      end
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      req_in    = req_ff;
      cnt_in    = cnt_ff;
      maxf_in   = maxf_ff;
      maxl_in   = maxl_ff;
      goal_in   = goal_ff;
      rd_in     = rd_ff;
      cmp_in    = rd_ff;
      cmpv_in   = 1'b0;
      found_in  = found_ff;
      best_in   = best_ff;
      bkey_in   = bkey_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      odata_in  = odata_ff;
      wr_en     = 1'b0;
      wr_addr   = best_ff;
      wr_slot   = rd_slot;

      if (csr_write) begin
         if (csr_index == dpb_pkg::CSR_MAX_FRAMES) begin
            maxf_in = csr_wdata[4:0];
         end else begin
            maxl_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               req_in.is_ref = eff_ref;
               status_in     = 1'b0;
               rd_in         = '0;
               found_in      = 1'b0;
               case (req_data.operation)
                  dpb_pkg::OP_ADD: begin
                     goal_in  = G_PEND;
                     state_in = S_SCAN;
                  end
                  dpb_pkg::OP_FLUSH: begin
                     goal_in  = G_PEND;
                     state_in = req_data.flush_emit ? S_SCAN : S_DONE;
                  end
                  dpb_pkg::OP_SLIDING: begin
                     goal_in  = G_SLIDE;
                     state_in = (cnt_ff == cap) ? S_SCAN : S_DONE;
                  end
                  dpb_pkg::OP_MARK_LONG, dpb_pkg::OP_UNMARK_ST,
                  dpb_pkg::OP_UNMARK_LT: begin
                     goal_in  = G_MATCH;
                     state_in = S_SCAN;
                  end
                  dpb_pkg::OP_UNMARK_ALL: begin
                     goal_in  = G_ALL;
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_LIST;
                  end
               endcase
            end
         end

         // Walk slots: read issued at rd, compared in the following cycle.
         S_SCAN: begin
            if (cmpv_ff && better) begin
               found_in = 1'b1;
               best_in  = cmp_ff[AW-1:0];
               bkey_in  = key;
            end
            if (rd_ff < cnt_ff
                && !(cmpv_ff && better && (goal_ff == G_MATCH || goal_ff == G_ALL))) begin
               rd_in   = rd_ff + 1'b1;
               cmpv_in = 1'b1;
            end else begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            case (req_ff.operation)
               dpb_pkg::OP_ADD: begin
                  if (req_ff.is_ref && cnt_ff < cap) begin
                     state_in = S_ADDNEW;
                  end else if (req_ff.is_ref && !bump_ok) begin
                     status_in = 1'b1;
                     state_in  = S_DONE;
                  end else if (bump_ok) begin
                     rd_in    = CW'(best_ff);
                     state_in = S_RDSEL;
                  end else begin
                     // The added non-reference frame leaves last.
                     if (out_free) begin
                        ovalid_in = 1'b1;
                        odata_in  = '0;
                        odata_in.kind            = dpb_pkg::KIND_FRAME;
                        odata_in.out_tag         = req_ff.frame_tag;
                        odata_in.out_order_count = req_ff.order_count;
                        odata_in.out_frame_index = req_ff.frame_index;
                        odata_in.out_is_long     = req_ff.is_long;
                        odata_in.last            = 1'b1;
                        state_in = S_SENDW;
                     end
                  end
               end
               dpb_pkg::OP_FLUSH: begin
                  if (bump_ok) begin
                     rd_in    = CW'(best_ff);
                     state_in = S_RDSEL;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  if (found_ff) begin
                     rd_in    = CW'(best_ff);
                     state_in = S_RDSEL;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            endcase
         end

         S_RDSEL: begin
            state_in = S_ACT;
         end

         // Apply the operation to the chosen slot (rd_slot holds it).
         S_ACT: begin
            wr_addr = best_ff;
            wr_slot = rd_slot;
            pos_in  = CW'(best_ff);
            if (goal_ff == G_PEND) begin
               if (out_free) begin
                  ovalid_in = 1'b1;
                  odata_in  = '0;
                  odata_in.kind            = dpb_pkg::KIND_FRAME;
                  odata_in.out_tag         = rd_slot.tag;
                  odata_in.out_order_count = rd_slot.poc;
                  odata_in.out_frame_index = rd_slot.idx;
                  odata_in.out_is_long     = rd_slot.flags[dpb_pkg::FLAG_LONG];
                  odata_in.out_is_ref      = rd_slot.flags[dpb_pkg::FLAG_REF];
                  wr_en = 1'b1;
                  wr_slot.flags[dpb_pkg::FLAG_PEND] = 1'b0;
                  ret_in   = S_SCAN;
                  rd_in    = CW'(best_ff) + 1'b1;
                  state_in = rd_slot.flags[dpb_pkg::FLAG_REF] ? S_SENDW : S_SHIFT;
                  if (!rd_slot.flags[dpb_pkg::FLAG_REF]) begin
                     cmpv_in = 1'b0;
                  end
               end
            end else if (req_ff.operation == dpb_pkg::OP_MARK_LONG) begin
               wr_en = 1'b1;
               wr_slot.flags[dpb_pkg::FLAG_LONG] = 1'b1;
               wr_slot.idx = req_ff.new_long_index;
               state_in = S_DONE;
            end else begin
               wr_en = 1'b1;
               wr_slot.flags[dpb_pkg::FLAG_REF] = 1'b0;
               ret_in = (goal_ff == G_ALL) ? S_SCAN : S_DONE;
               if (!rd_slot.flags[dpb_pkg::FLAG_PEND]) begin
                  rd_in    = CW'(best_ff) + 1'b1;
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_RDWAIT;
               end
            end
         end

         // Compaction: slot pos takes slot pos+1 (read issued in the previous cycle).
         S_SHIFT: begin
            if (cmpv_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_slot = rd_slot;
               pos_in  = pos_ff + 1'b1;
            end
            if (rd_ff < cnt_ff) begin
               rd_in   = rd_ff + 1'b1;
               cmpv_in = 1'b1;
            end else if (!cmpv_ff) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_RDWAIT;
            end
         end

         // Return to caller; the read address and found flag are reset for a fresh scan.
         S_RDWAIT: begin
            rd_in    = '0;
            found_in = 1'b0;
            state_in = ret_ff;
            if (ret_ff == S_SCAN && goal_ff == G_PEND && ovalid_ff) begin
               state_in = S_SENDW;
            end
         end

         S_SENDW: begin
            if (!ovalid_ff || !rsp_stall) begin
               if (odata_ff.last) begin
                  if (!ovalid_ff || !rsp_stall) state_in = S_IDLE;
               end else begin
                  state_in = S_RDWAIT;
                  ret_in   = S_SCAN;
               end
            end
         end

         S_ADDNEW: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            wr_slot.tag   = req_ff.frame_tag;
            wr_slot.poc   = req_ff.order_count;
            wr_slot.idx   = req_ff.frame_index;
            wr_slot.flags = {req_ff.needs_output, req_ff.is_long, 1'b1};
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_DONE;
         end

         // List walk: one entry per free output cycle; a stalled entry is read again.
         S_LIST: begin
            if (!cmpv_ff) begin
               rd_in   = rd_ff + 1'b1;
               cmpv_in = 1'b1;
            end else if (out_free) begin
               ovalid_in = 1'b1;
               odata_in  = '0;
               odata_in.kind = dpb_pkg::KIND_ENTRY;
               if (cmp_ff < cnt_ff) begin
                  odata_in.out_tag         = rd_slot.tag;
                  odata_in.out_order_count = rd_slot.poc;
                  odata_in.out_frame_index = rd_slot.idx;
                  odata_in.out_is_long     = rd_slot.flags[dpb_pkg::FLAG_LONG];
                  odata_in.out_is_ref      = rd_slot.flags[dpb_pkg::FLAG_REF];
                  odata_in.entry_valid     = 1'b1;
               end
               if (rd_ff == DEPTH_C) begin
                  state_in = S_DONE;
               end else begin
                  rd_in   = rd_ff + 1'b1;
                  cmpv_in = 1'b1;
               end
            end else begin
               rd_in = cmp_ff;
            end
         end

         S_DONE: begin
            if (out_free) begin
               if (req_ff.operation == dpb_pkg::OP_FLUSH) begin
                  cnt_in = '0;
               end
               ovalid_in = 1'b1;
               odata_in  = '0;
               odata_in.kind   = dpb_pkg::KIND_DONE;
               odata_in.status = status_ff;
               odata_in.last   = 1'b1;
               state_in = S_SENDW;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_DONE;
         cnt_ff    <= '0;
         maxf_ff   <= dpb_pkg::MAX_FRAMES_RESET;
         maxl_ff   <= dpb_pkg::MAX_LONG_RESET;
         ovalid_ff <= 1'b0;
         cmpv_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         cnt_ff    <= cnt_in;
         maxf_ff   <= maxf_in;
         maxl_ff   <= maxl_in;
         ovalid_ff <= ovalid_in;
         cmpv_ff   <= cmpv_in;
         found_ff  <= found_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      goal_ff   <= goal_in;
      rd_ff     <= rd_in;
      cmp_ff    <= cmp_in;
      best_ff   <= best_in;
      bkey_ff   <= bkey_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      odata_ff  <= odata_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_data  = odata_ff;

   // The stored count never exceeds the slot count.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_C) else $error("stored count out of range");

   // A new operation is taken only when no result other than a last one is pending.
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !(ovalid_ff && !odata_ff.last))
      else $error("operation accepted with a result pending");

   // A frame is added only with room below the slot count.
   a_add_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADDNEW) |-> (cnt_ff < DEPTH_C))
      else $error("add without room");

endmodule
